// File: rtl/core/rdag_pkg.sv
// shared types and constants for the rotated diagonal address generator
package rdag_pkg;

    localparam int unsigned EXT_W   = 13;
    localparam int unsigned START_W = 16;
    localparam int unsigned PITCH_W = 16;
    localparam int unsigned IN_W    = 12;
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_EXTENT      = 3'd0,
        CFG_COL_EXTENT      = 3'd1,
        CFG_ROW_START       = 3'd2,
        CFG_COL_START       = 3'd3,
        CFG_ROW_PITCH       = 3'd4,
        CFG_TRANSPOSED_MODE = 3'd5
    } cfg_idx_t;

endpackage

// File: rtl/core/rotated_diagonal_address_gen.sv
// rotated diagonal address generator: slot to submatrix element lookup
//
// For each request (diagonal, rotation, slot) the block returns the padded
// row and column of the submatrix element that lands in that slot of the
// rotated generalized diagonal, its flat row-major address in the full
// matrix, and flags for zero padding and for a slot past the vector length.
// Request and result channels use valid/stall; a request is taken when
// req_valid is high and req_stall is low, a result is taken when res_valid
// is high and res_stall is low. The configuration port writes one register
// per cfg_valid/cfg_ready handshake; cfg_ready is always high.
// A request passes through the request register, then one pass of index logic
// and the address multiply-add into the result register. Throughput is one
// request per cycle while res_stall is low; the rate is set by that single-pass stage.
// When the receiver stalls, the result register holds and the request
// register takes one more request, if it was empty, before req_stall rises.
// Reset clears both valid flags and loads the default configuration.
module rotated_diagonal_address_gen #(
    parameter int SLOTS = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rdag_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rdag_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [rdag_pkg::IN_W-1:0]         diagonal,
    input  logic [rdag_pkg::IN_W-1:0]         rotation,
    input  logic [rdag_pkg::IN_W-1:0]         slot,
    output logic                              res_valid,
    input  logic                              res_stall,
    output logic [rdag_pkg::EXT_W-1:0]        source_row,
    output logic [rdag_pkg::EXT_W-1:0]        source_col,
    output logic [rdag_pkg::ADDR_W-1:0]       element_address,
    output logic                              is_padding,
    output logic                              past_length
);

    localparam int LW  = $clog2(SLOTS);
    localparam int WW  = (LW > 13) ? LW + 1 : 14;
    localparam int SUM_W = rdag_pkg::START_W + 1;
    localparam int PROD_W = SUM_W + rdag_pkg::PITCH_W;
    localparam logic [LW-1:0] HALF_MASK = LW'((SLOTS / 2) - 1);

    // configuration registers
    logic [rdag_pkg::EXT_W-1:0]   row_extent_reg;
    logic [rdag_pkg::EXT_W-1:0]   col_extent_reg;
    logic [rdag_pkg::START_W-1:0] row_start_reg;
    logic [rdag_pkg::START_W-1:0] col_start_reg;
    logic [rdag_pkg::PITCH_W-1:0] row_pitch_reg;
    logic                         transposed_reg;
    logic                         cfg_we;

    // request stage
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic [rdag_pkg::IN_W-1:0]    s1_diag_reg;
    logic [rdag_pkg::IN_W-1:0]    s1_rot_reg;
    logic [rdag_pkg::IN_W-1:0]    s1_slot_reg;
    logic                         s1_load;

    // result stage
    logic                         res_valid_reg;
    logic                         res_valid_next;
    logic                         res_adv;
    logic [rdag_pkg::EXT_W-1:0]   source_row_reg;
    logic [rdag_pkg::EXT_W-1:0]   source_col_reg;
    logic [rdag_pkg::ADDR_W-1:0]  element_address_reg;
    logic                         is_padding_reg;
    logic                         past_length_reg;
    logic [rdag_pkg::EXT_W-1:0]   source_row_next;
    logic [rdag_pkg::EXT_W-1:0]   source_col_next;
    logic [rdag_pkg::ADDR_W-1:0]  element_address_next;
    logic                         is_padding_next;
    logic                         past_length_next;

    // index datapath
    logic [LW-1:0]     row_span;
    logic [LW-1:0]     col_span;
    logic [LW-1:0]     max_mask;
    logic [LW-1:0]     rot_mask;
    logic [LW-1:0]     row_wrap;
    logic [LW-1:0]     col_wrap;
    logic [LW-1:0]     idx;
    logic [LW-1:0]     diag_l;
    logic [LW-1:0]     row_off;
    logic [LW-1:0]     col_off;
    logic [LW-1:0]     row_val;
    logic [LW-1:0]     col_val;
    logic [WW-1:0]     slot_w;
    logic              full_width;
    logic              upper;
    logic              past;
    logic              pad;
    logic [SUM_W-1:0]  row_sum;
    logic [PROD_W-1:0] prod;
    logic [rdag_pkg::ADDR_W-1:0] addr;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_extent_reg <= rdag_pkg::EXT_W'(1);
            col_extent_reg <= rdag_pkg::EXT_W'(1);
            row_start_reg  <= '0;
            col_start_reg  <= '0;
            row_pitch_reg  <= rdag_pkg::PITCH_W'(1);
            transposed_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rdag_pkg::CFG_ROW_EXTENT:
                    row_extent_reg <= cfg_data[rdag_pkg::EXT_W-1:0];
                rdag_pkg::CFG_COL_EXTENT:
                    col_extent_reg <= cfg_data[rdag_pkg::EXT_W-1:0];
                rdag_pkg::CFG_ROW_START:
                    row_start_reg <= cfg_data[rdag_pkg::START_W-1:0];
                rdag_pkg::CFG_COL_START:
                    col_start_reg <= cfg_data[rdag_pkg::START_W-1:0];
                rdag_pkg::CFG_ROW_PITCH:
                    row_pitch_reg <= cfg_data[rdag_pkg::PITCH_W-1:0];
                rdag_pkg::CFG_TRANSPOSED_MODE:
                    transposed_reg <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // handshake control
    assign res_adv   = !res_valid_reg || !res_stall;
    assign req_stall = s1_valid_reg && !res_adv;
    assign s1_load   = req_valid && !req_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (!s1_valid_reg || res_adv)
        begin
            s1_valid_next = req_valid;
        end
        res_valid_next = res_valid_reg;
        if (res_adv)
        begin
            res_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_diag_reg <= diagonal;
            s1_rot_reg  <= rotation;
            s1_slot_reg <= slot;
        end
        if (res_adv)
        begin
            source_row_reg      <= source_row_next;
            source_col_reg      <= source_col_next;
            element_address_reg <= element_address_next;
            is_padding_reg      <= is_padding_next;
            past_length_reg     <= past_length_next;
        end
    end

    // padded extents as low-bit masks, saturating at the slot count
    always_comb
    begin
        for (int i = 0; i < LW; i++)
        begin
            row_span[i] = WW'(row_extent_reg) > (WW'(1) << i);
            col_span[i] = WW'(col_extent_reg) > (WW'(1) << i);
        end
    end

    assign max_mask   = row_span | col_span;
    assign full_width = max_mask[LW-1];
    assign rot_mask   = full_width ? HALF_MASK : max_mask;

    assign slot_w = WW'(s1_slot_reg);
    assign past   = slot_w > WW'(max_mask);
    assign upper  = slot_w[LW-1];

    // right rotation: slot minus amount, modulo the rotated length
    assign idx    = (LW'(s1_slot_reg) - LW'(s1_rot_reg)) & rot_mask;
    assign diag_l = LW'(s1_diag_reg);
    assign row_off = transposed_reg ? diag_l : '0;
    assign col_off = transposed_reg ? '0 : diag_l;

    assign row_wrap = (full_width && transposed_reg) ? (row_span & HALF_MASK) : row_span;
    assign col_wrap = (full_width && !transposed_reg) ? (col_span & HALF_MASK) : col_span;

    // upper half of the slots reaches the upper half of a wide extent
    assign row_val = ((idx + row_off) & row_wrap)
                   | {upper & row_span[LW-1], {(LW-1){1'b0}}};
    assign col_val = ((idx + col_off) & col_wrap)
                   | {upper & col_span[LW-1], {(LW-1){1'b0}}};

    assign pad = (WW'(row_val) >= WW'(row_extent_reg))
              || (WW'(col_val) >= WW'(col_extent_reg));

    assign row_sum = SUM_W'(row_start_reg) + SUM_W'(row_val);
    assign prod    = PROD_W'(row_sum) * PROD_W'(row_pitch_reg);
    assign addr    = prod[rdag_pkg::ADDR_W-1:0]
                   + rdag_pkg::ADDR_W'(col_start_reg)
                   + rdag_pkg::ADDR_W'(col_val);

    always_comb
    begin
        if (past)
        begin
            source_row_next      = '0;
            source_col_next      = '0;
            element_address_next = '0;
            is_padding_next      = 1'b1;
            past_length_next     = 1'b1;
        end
        else
        begin
            source_row_next      = rdag_pkg::EXT_W'(row_val);
            source_col_next      = rdag_pkg::EXT_W'(col_val);
            element_address_next = pad ? '0 : addr;
            is_padding_next      = pad;
            past_length_next     = 1'b0;
        end
    end

    assign res_valid       = res_valid_reg;
    assign source_row      = source_row_reg;
    assign source_col      = source_col_reg;
    assign element_address = element_address_reg;
    assign is_padding      = is_padding_reg;
    assign past_length     = past_length_reg;

    a_past_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && past_length |-> is_padding && element_address == '0
            && source_row == '0 && source_col == '0)
        else $error("past-length result not zeroed");

    a_pad_addr: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && is_padding |-> element_address == '0)
        else $error("padding result carries an address");

    a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !is_padding |-> source_row < row_extent_reg
            && source_col < col_extent_reg)
        else $error("non-padding result outside extents");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> s1_valid_reg && res_valid_reg && res_stall)
        else $error("request stalled without a full pipeline");

    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && res_valid_reg && res_stall |=> s1_valid_reg)
        else $error("request dropped while result stalled");

endmodule
